/* rtl/bfa_pkg.sv */
// bfa_pkg: shared types and constants for the bitmap frame allocator
// used by bitmap_frame_allocator and bfa_zero_find; no dependencies

package bfa_pkg;

    localparam int MAP_WORD_W = 32;
    localparam int BIT_POS_W  = 5;
    localparam int FRAME_W    = 10;
    localparam int OP_W       = 2;

    localparam logic [MAP_WORD_W-1:0] FULL_WORD = 32'hFFFF_FFFF;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FRAME_W-1:0] frame_index;
    } t_in_word;

    typedef struct packed {
        logic [FRAME_W-1:0] result_frame;
        logic               found;
        logic               was_used;
    } t_out_word;

    // result of the lowest-clear-bit search over one map word
    typedef struct packed {
        logic                 has_zero;
        logic [BIT_POS_W-1:0] pos;
    } t_find;

endpackage

/* rtl/bfa_ram.sv */
// bfa_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/bfa_zero_find.sv */
// bfa_zero_find: finds the lowest clear bit of one 32-bit map word
// depends on bfa_pkg

module bfa_zero_find (
    input  logic [bfa_pkg::MAP_WORD_W-1:0] i_word,
    output bfa_pkg::t_find                 o_find
);

    always_comb begin
        o_find.has_zero = (i_word != bfa_pkg::FULL_WORD);
        o_find.pos      = '0;
        // scan downward so the lowest clear bit wins
        for (int i = bfa_pkg::MAP_WORD_W - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_find.pos = bfa_pkg::BIT_POS_W'(i);
            end
        end
    end

endmodule

/* rtl/bitmap_frame_allocator.sv */
// bitmap_frame_allocator: page-frame allocator over a one-bit-per-frame used map
// depends on bfa_pkg, bfa_ram and bfa_zero_find
//
// usage
//   input channel (i_in_valid / o_in_ready / i_in_word) carries one request word:
//   allocate lowest free frame, free a frame, or test a frame
//   output channel (o_out_valid / i_out_ready / o_out_word) returns one result
//   word per request, in request order
//   the map lives in a RAM of ceil(FRAME_COUNT/32) words of 32 bits
//   allocate scans the map one word per cycle through a single clear-bit finder;
//   a request whose lowest free frame sits in word w reads words 0 to w, marks the
//   frame used and passes the result through S_DONE into the output register
//   free and test do one RAM read, then update or answer,
//   an unknown op or an out-of-range frame is answered without a RAM read
//   one request is in work at a time; o_in_ready rises again once the result
//   sits in the output register, so the next request can be accepted
//   even while the receiver has not yet taken that result
//   if the receiver stalls, a finished result waits in a holding register
//   until the output register frees up
//   after reset a clearing pass over all MAP_WORDS words writes the
//   initial map, reserved frames set, before the first request is accepted

module bitmap_frame_allocator #(
    parameter int FRAME_COUNT     = 1024,
    parameter int RESERVED_FRAMES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bfa_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bfa_pkg::t_out_word  o_out_word
);

    localparam int MAP_WORDS = (FRAME_COUNT + 31) / 32;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CW        = AW + 1;
    localparam int CMP_W     = 18;
    localparam int RES_EFF   = (RESERVED_FRAMES < FRAME_COUNT) ? RESERVED_FRAMES
                                                               : FRAME_COUNT;
    localparam int RES_TAIL  = RES_EFF % 32;

    localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [CW-1:0]    RES_FULL  = CW'(RES_EFF / 32);
    localparam logic [CMP_W-1:0] FC_LIMIT  = CMP_W'(FRAME_COUNT);
    localparam logic [bfa_pkg::MAP_WORD_W-1:0] TAIL_MASK =
        bfa_pkg::MAP_WORD_W'((64'd1 << RES_TAIL) - 64'd1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_LOOK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    logic [AW-1:0]                r_word, n_word;
    logic [bfa_pkg::OP_W-1:0]     r_op, n_op;
    logic [bfa_pkg::FRAME_W-1:0]  r_idx, n_idx;
    bfa_pkg::t_out_word           r_res, n_res;
    bfa_pkg::t_out_word           r_out, n_out;
    logic                         r_out_vld, n_out_vld;

    // map RAM ports
    logic                            ram_we;
    logic [AW-1:0]                   ram_wa;
    logic [bfa_pkg::MAP_WORD_W-1:0]  ram_wd;
    logic                            ram_re;
    logic [AW-1:0]                   ram_ra;
    logic [bfa_pkg::MAP_WORD_W-1:0]  ram_rd;

    bfa_pkg::t_find                  find;

    logic                            in_acc;
    logic                            out_free;
    logic [AW-1:0]                   idx_word;
    logic                            idx_in_range;
    logic [AW+bfa_pkg::BIT_POS_W-1:0] scan_frame;
    logic                            scan_frame_ok;
    logic [bfa_pkg::MAP_WORD_W-1:0]  scan_mask;
    logic [bfa_pkg::MAP_WORD_W-1:0]  idx_mask;
    logic [bfa_pkg::MAP_WORD_W-1:0]  init_word;

    bfa_ram #(
        .WIDTH (bfa_pkg::MAP_WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    // single clear-bit finder for the allocate scan, fed by the word read last cycle
    bfa_zero_find u_find (
        .i_word (ram_rd),
        .o_find (find)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_vld || i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // word holding the requested frame; only used when the frame is in range
    assign idx_word     = AW'({11'd0, i_in_word.frame_index[bfa_pkg::FRAME_W-1:5]});
    assign idx_in_range = ({8'd0, i_in_word.frame_index} < FC_LIMIT);

    // candidate frame from the current scan word; bits past the map end read clear
    assign scan_frame    = {r_word, find.pos};
    assign scan_frame_ok = (CMP_W'(scan_frame) < FC_LIMIT);
    assign scan_mask     = bfa_pkg::MAP_WORD_W'(1) << find.pos;
    assign idx_mask      = bfa_pkg::MAP_WORD_W'(1) << r_idx[bfa_pkg::BIT_POS_W-1:0];

    // initial contents: whole words of reserved frames, then one partial word
    always_comb begin
        if ({1'b0, r_word} < RES_FULL) begin
            init_word = bfa_pkg::FULL_WORD;
        end else if ({1'b0, r_word} == RES_FULL) begin
            init_word = TAIL_MASK;
        end else begin
            init_word = '0;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_word    = r_word;
        n_op      = r_op;
        n_idx     = r_idx;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        ram_we    = 1'b0;
        ram_wa    = r_word;
        ram_wd    = ram_rd;
        ram_re    = 1'b0;
        ram_ra    = r_word;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_wd = init_word;
                if (r_word == LAST_WORD) begin
                    n_word  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_word = r_word + AW'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op  = i_in_word.op;
                    n_idx = i_in_word.frame_index;
                    if (i_in_word.op == bfa_pkg::OP_ALLOC) begin
                        // start the scan at word 0
                        ram_re  = 1'b1;
                        ram_ra  = '0;
                        n_word  = '0;
                        n_state = S_SCAN;
                    end else if ((i_in_word.op == bfa_pkg::OP_FREE ||
                                  i_in_word.op == bfa_pkg::OP_TEST) && idx_in_range) begin
                        ram_re  = 1'b1;
                        ram_ra  = idx_word;
                        n_word  = idx_word;
                        n_state = S_LOOK;
                    end else begin
                        // unknown op or frame past the map: answer at once
                        n_res.result_frame = i_in_word.frame_index;
                        n_res.found        = 1'b0;
                        n_res.was_used     = 1'b0;
                        n_state            = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (find.has_zero) begin
                    n_state = S_DONE;
                    if (scan_frame_ok) begin
                        ram_we             = 1'b1;
                        ram_wd             = ram_rd | scan_mask;
                        n_res.result_frame = bfa_pkg::FRAME_W'(scan_frame);
                        n_res.found        = 1'b1;
                    end else begin
                        // first clear bit lies past the last frame: map full
                        n_res.result_frame = '0;
                        n_res.found        = 1'b0;
                    end
                    n_res.was_used = 1'b0;
                end else if (r_word == LAST_WORD) begin
                    n_res.result_frame = '0;
                    n_res.found        = 1'b0;
                    n_res.was_used     = 1'b0;
                    n_state            = S_DONE;
                end else begin
                    ram_re = 1'b1;
                    ram_ra = r_word + AW'(1);
                    n_word = r_word + AW'(1);
                end
            end
            S_LOOK: begin
                n_res.result_frame = r_idx;
                n_res.found        = 1'b1;
                n_res.was_used     = (r_op == bfa_pkg::OP_TEST) &&
                                     ram_rd[r_idx[bfa_pkg::BIT_POS_W-1:0]];
                if (r_op == bfa_pkg::OP_FREE) begin
                    ram_we = 1'b1;
                    ram_wd = ram_rd & ~idx_mask;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_word    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_word    <= n_word;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_idx <= n_idx;
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule
